### design/multi_channel_watchdog_top_assert.svh
// assertion macros for the multi-channel watchdog checker
`ifndef MULTI_CHANNEL_WATCHDOG_TOP_ASSERT_SVH
`define MULTI_CHANNEL_WATCHDOG_TOP_ASSERT_SVH

// clocked assertion, off while reset is low
`define MCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define MCW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mcw_pkg.sv
// types, codes and constants shared by the multi-channel watchdog
`timescale 1ns / 1ps
package mcw_pkg;

    localparam int CHANNELS_DEF   = 16;
    localparam int OP_W           = 2;
    localparam int TIMEOUT_W      = 16;
    localparam int CHAN_W         = 4;
    localparam int STATUS_W       = 2;
    localparam int PERIOD_W       = 16;
    localparam int NOW_W          = 32;
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 16'd10;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_OPEN  = 2'd1;
    localparam logic [OP_W-1:0] OP_KICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_CHANNEL = 2'd3;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_SCAN,
        CMD_OPEN,
        CMD_KICK,
        CMD_CLOSE,
        CMD_BAD_TMO,
        CMD_BAD_CHAN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [TIMEOUT_W-1:0]   timeout;
        logic [CHAN_W-1:0]      chan;
        logic [NOW_W-1:0]       now;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [CHAN_W-1:0]      opened_channel;
        logic                   heartbeat;
        logic                   any_expired;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SCAN_LAST,
        BK_OPEN,
        BK_KICK
    } back_state_t;

endpackage

### design/mcw_item_if.sv
// input word channel of the watchdog
`timescale 1ns / 1ps
interface mcw_item_if;
    import mcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [CHAN_W-1:0]    channel;

    modport source (output valid, output op, output timeout_ticks, output channel,
                    input ready);
    modport sink   (input valid, input op, input timeout_ticks, input channel,
                    output ready);
endinterface

### design/mcw_result_if.sv
// result word channel of the watchdog
`timescale 1ns / 1ps
interface mcw_result_if;
    import mcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAN_W-1:0]   opened_channel;
    logic                heartbeat;
    logic                any_expired;

    modport source (output valid, output status, output opened_channel,
                    output heartbeat, output any_expired, input ready);
    modport sink   (input valid, input status, input opened_channel,
                    input heartbeat, input any_expired, output ready);
endinterface

### design/mcw_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module mcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### design/mcw_front.sv
// front end: time base, scan phase, period register and command classification
`timescale 1ns / 1ps
module mcw_front #(
    parameter int CHANNELS = mcw_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mcw_pkg::OP_W-1:0]       op,
    input  logic [mcw_pkg::TIMEOUT_W-1:0]  timeout_ticks,
    input  logic [mcw_pkg::CHAN_W-1:0]     channel,
    input  logic                           cfg_we,
    input  logic [mcw_pkg::PERIOD_W-1:0]   cfg_wdata,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output mcw_pkg::cmd_t                  cmd
);
    import mcw_pkg::*;

    logic [NOW_W-1:0]    now_reg, now_next;
    logic [PERIOD_W-1:0] phase_reg, phase_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W:0]   phase_inc;
    logic                scan_hit;
    logic                chan_ok;
    logic                accept;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    // a zero period behaves as one
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign phase_inc  = {1'b0, phase_reg} + (PERIOD_W + 1)'(1);
    assign scan_hit   = (phase_inc >= {1'b0, period_eff});
    assign chan_ok    = (32'(channel) < 32'(CHANNELS));

    always_comb
    begin
        cmd.timeout = timeout_ticks;
        cmd.chan    = channel;
        cmd.now     = now_reg;
        cmd.kind    = CMD_TICK;
        case (op)
            OP_TICK:
            begin
                cmd.now  = now_reg + NOW_W'(1);
                cmd.kind = scan_hit ? CMD_SCAN : CMD_TICK;
            end
            OP_OPEN:  cmd.kind = (timeout_ticks == '0) ? CMD_BAD_TMO : CMD_OPEN;
            OP_KICK:  cmd.kind = chan_ok ? CMD_KICK : CMD_BAD_CHAN;
            OP_CLOSE: cmd.kind = chan_ok ? CMD_CLOSE : CMD_BAD_CHAN;
            default:  cmd.kind = CMD_TICK;
        endcase
    end

    always_comb
    begin
        now_next    = now_reg;
        phase_next  = phase_reg;
        period_next = cfg_we ? cfg_wdata : period_reg;
        if (accept && (op == OP_TICK))
        begin
            now_next   = now_reg + NOW_W'(1);
            phase_next = scan_hit ? '0 : phase_inc[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            phase_reg  <= '0;
            period_reg <= CHECK_PERIOD_RST;
        end
        else
        begin
            now_reg    <= now_next;
            phase_reg  <= phase_next;
            period_reg <= period_next;
        end
    end
endmodule

### design/mcw_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps
module mcw_cmd_fifo #(
    parameter int DEPTH = mcw_pkg::CMD_FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  mcw_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output mcw_pkg::cmd_t rd_cmd
);
    import mcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

### design/mcw_back.sv
// back end: channel table, scan and open walks, result register
`timescale 1ns / 1ps
module mcw_back #(
    parameter int CHANNELS = mcw_pkg::CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  mcw_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output mcw_pkg::res_t res
);
    import mcw_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

    back_state_t         state_reg, state_next;
    logic [CH_W-1:0]     idx_reg, idx_next;
    cmd_t                cur_reg, cur_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic                pend_reg, pend_next;
    logic                exp_reg, exp_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic                 take;
    logic [CH_W-1:0]      cmd_idx;
    logic [CH_W-1:0]      cur_idx;
    logic [NOW_W-1:0]     diff;
    logic                 hit;
    logic                 exp_all;

    logic                 dl_we, dl_re;
    logic [CH_W-1:0]      dl_waddr, dl_raddr;
    logic [NOW_W-1:0]     dl_wdata, dl_rdata;
    logic                 tm_we;
    logic [TIMEOUT_W-1:0] tm_rdata;

    mcw_ram #(.WIDTH(NOW_W), .DEPTH(CHANNELS)) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .re    (dl_re),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    mcw_ram #(.WIDTH(TIMEOUT_W), .DEPTH(CHANNELS)) u_timeout_ram (
        .clk   (clk),
        .we    (tm_we),
        .waddr (idx_reg),
        .wdata (cur_reg.timeout),
        .re    (take),
        .raddr (cmd_idx),
        .rdata (tm_rdata)
    );

    assign cmd_idx = CH_W'(cmd.chan);
    assign cur_idx = CH_W'(cur_reg.chan);

    // signed wrap-safe now minus deadline greater than zero
    assign diff    = cur_reg.now - dl_rdata;
    assign hit     = pend_reg && (diff != '0) && !diff[NOW_W-1];
    assign exp_all = exp_reg | hit;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    case (cmd.kind)
                        CMD_SCAN: state_next = BK_SCAN;
                        CMD_OPEN: state_next = BK_OPEN;
                        CMD_KICK: state_next = active_reg[cmd_idx] ? BK_KICK : BK_IDLE;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_SCAN:      state_next = (idx_reg == LAST_IDX) ? BK_SCAN_LAST : BK_SCAN;
            BK_SCAN_LAST: state_next = BK_IDLE;
            BK_OPEN:
            begin
                if (!active_reg[idx_reg] || (idx_reg == LAST_IDX))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_KICK:      state_next = BK_IDLE;
            default:      state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_ready      = (state_reg == BK_IDLE) && (!res_valid_reg || res_ready);
        take           = cmd_valid && cmd_ready;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        active_next    = active_reg;
        pend_next      = 1'b0;
        exp_next       = exp_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        dl_we          = 1'b0;
        dl_re          = 1'b0;
        dl_waddr       = idx_reg;
        dl_raddr       = idx_reg;
        dl_wdata       = cur_reg.now + NOW_W'(cur_reg.timeout);
        tm_we          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    cur_next = cmd;
                    idx_next = '0;
                    exp_next = 1'b0;
                    res_next = '0;
                    case (cmd.kind)
                        CMD_TICK:    res_valid_next = 1'b1;
                        CMD_BAD_TMO:
                        begin
                            res_valid_next = 1'b1;
                            res_next.status = STAT_BAD_TIMEOUT;
                        end
                        CMD_BAD_CHAN:
                        begin
                            res_valid_next = 1'b1;
                            res_next.status = STAT_BAD_CHANNEL;
                        end
                        CMD_KICK:
                        begin
                            if (!active_reg[cmd_idx])
                            begin
                                res_valid_next = 1'b1;
                                res_next.status = STAT_BAD_CHANNEL;
                            end
                        end
                        CMD_CLOSE:
                        begin
                            res_valid_next = 1'b1;
                            if (active_reg[cmd_idx])
                            begin
                                active_next[cmd_idx] = 1'b0;
                            end
                            else
                            begin
                                res_next.status = STAT_BAD_CHANNEL;
                            end
                        end
                        default:     res_valid_next = 1'b0;
                    endcase
                end
            end
            BK_SCAN:
            begin
                dl_re     = 1'b1;
                pend_next = active_reg[idx_reg];
                exp_next  = exp_all;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + CH_W'(1);
                end
            end
            BK_SCAN_LAST:
            begin
                res_valid_next       = 1'b1;
                res_next             = '0;
                res_next.heartbeat   = !exp_all;
                res_next.any_expired = exp_all;
            end
            BK_OPEN:
            begin
                if (!active_reg[idx_reg])
                begin
                    dl_we                   = 1'b1;
                    tm_we                   = 1'b1;
                    active_next[idx_reg]    = 1'b1;
                    res_valid_next          = 1'b1;
                    res_next                = '0;
                    res_next.opened_channel = CHAN_W'(idx_reg);
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_valid_next  = 1'b1;
                    res_next        = '0;
                    res_next.status = STAT_NO_FREE;
                end
                else
                begin
                    idx_next = idx_reg + CH_W'(1);
                end
            end
            BK_KICK:
            begin
                dl_we          = 1'b1;
                dl_waddr       = cur_idx;
                dl_wdata       = cur_reg.now + NOW_W'(tm_rdata);
                res_valid_next = 1'b1;
                res_next       = '0;
            end
            default:
            begin
                res_valid_next = res_valid_reg && !res_ready;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            active_reg    <= '0;
            pend_reg      <= 1'b0;
            exp_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            exp_reg       <= exp_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule

### design/multi_channel_watchdog_top.sv
// Multi-channel watchdog: a front end keeps the tick counter, the scan phase and the
// check_period register and turns each input word into a command; a four-entry queue
// passes commands to a back-end sequencer that owns the channel table (active bits in
// flops, deadlines and timeouts in two small rams) and one output register. Ticks that
// do not scan, close, and rejected words finish in the fetch state; kick reads the
// timeout ram, then writes the deadline; open walks the channels from the first until
// a free one or the last; a scan reads the deadline of each channel in turn and then
// does a final compare. No clearing pass is needed after reset; the next input word is
// taken into the queue while a result waits to be read, as long as the queue has room.
`timescale 1ns / 1ps
module multi_channel_watchdog_top #(
    parameter int CHANNELS = mcw_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mcw_item_if.sink                      item,
    mcw_result_if.source                  result,
    input  logic                          check_period_we,
    input  logic [mcw_pkg::PERIOD_W-1:0]  check_period_wdata
);
    import mcw_pkg::*;

    logic cf_valid, cf_ready;
    cmd_t cf_cmd;
    logic fb_valid, fb_ready;
    cmd_t fb_cmd;
    res_t res;

    mcw_front #(.CHANNELS(CHANNELS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item.valid),
        .in_ready      (item.ready),
        .op            (item.op),
        .timeout_ticks (item.timeout_ticks),
        .channel       (item.channel),
        .cfg_we        (check_period_we),
        .cfg_wdata     (check_period_wdata),
        .cmd_valid     (cf_valid),
        .cmd_ready     (cf_ready),
        .cmd           (cf_cmd)
    );

    mcw_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cf_valid),
        .wr_ready (cf_ready),
        .wr_cmd   (cf_cmd),
        .rd_valid (fb_valid),
        .rd_ready (fb_ready),
        .rd_cmd   (fb_cmd)
    );

    mcw_back #(.CHANNELS(CHANNELS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (fb_valid),
        .cmd_ready (fb_ready),
        .cmd       (fb_cmd),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res)
    );

    assign result.status         = res.status;
    assign result.opened_channel = res.opened_channel;
    assign result.heartbeat      = res.heartbeat;
    assign result.any_expired    = res.any_expired;
endmodule

### design/mcw_checker.sv
// port-level checker for the multi-channel watchdog and its bind
`timescale 1ns / 1ps
`include "multi_channel_watchdog_top_assert.svh"
module mcw_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  logic [mcw_pkg::STATUS_W-1:0] status,
    input  logic [mcw_pkg::CHAN_W-1:0]   opened_channel,
    input  logic                         heartbeat,
    input  logic                         any_expired
);
    import mcw_pkg::*;

    `MCW_ASSERT(a_res_hold, result_valid && !result_ready |=> result_valid && $stable({status, opened_channel, heartbeat, any_expired}), "stalled result word changed or dropped")
    `MCW_ASSERT(a_flags_excl, result_valid |-> !(heartbeat && any_expired), "heartbeat and expiry flagged together")
    `MCW_ASSERT(a_err_clean, result_valid && (status != STAT_OK) |-> !heartbeat && !any_expired && (opened_channel == '0), "error result carries scan or open data")
    `MCW_ASSERT_RST(a_rst_idle, !rst_n |=> !result_valid, "result valid during reset")
endmodule

bind multi_channel_watchdog_top mcw_checker u_mcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .status         (result.status),
    .opened_channel (result.opened_channel),
    .heartbeat      (result.heartbeat),
    .any_expired    (result.any_expired)
);

### verif/tb_multi_channel_watchdog_top.sv
// self-checking testbench for the multi-channel watchdog top level
`timescale 1ns / 1ps
module tb_multi_channel_watchdog_top;
    import mcw_pkg::*;

    localparam int NCHAN       = CHANNELS_DEF;
    localparam int SETTLE      = 40;
    localparam int HOLD_LEN    = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 65;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [TIMEOUT_W-1:0] tmo;
        logic [CHAN_W-1:0]    ch;
        int                   reps;
        bit                   typed;
        res_t                 want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic check_period_we = 1'b0;
    logic [PERIOD_W-1:0] check_period_wdata = '0;

    mcw_item_if   item_bus ();
    mcw_result_if result_bus ();

    multi_channel_watchdog_top DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .item               (item_bus),
        .result             (result_bus),
        .check_period_we    (check_period_we),
        .check_period_wdata (check_period_wdata)
    );

    // watchdog table as the block should hold it
    bit                   chan_on  [NCHAN];
    logic [TIMEOUT_W-1:0] chan_tmo [NCHAN];
    logic [NOW_W-1:0]     chan_due [NCHAN];
    logic [NOW_W-1:0]     tick_now;
    logic [PERIOD_W-1:0]  phase_cnt;
    logic [PERIOD_W-1:0]  period_reg;

    res_t pending_replies [$];
    stim_row_t script [13];

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int words_sent = 0;
    int replies_seen = 0;
    int heartbeats = 0;
    int expiries = 0;
    int holds_done = 0;

    always #2 clk = ~clk;

    function automatic res_t predict_watchdog_reply(input logic [OP_W-1:0] op,
                                                    input logic [TIMEOUT_W-1:0] tmo,
                                                    input logic [CHAN_W-1:0] ch);
        res_t r;
        logic [NOW_W-1:0] lap;
        logic [NOW_W-1:0] gap;
        bit late;
        bit found;
        int i;
        r = '0;
        late = 1'b0;
        found = 1'b0;
        case (op)
            OP_TICK:
            begin
                lap = (period_reg == '0) ? 32'd1 : {16'd0, period_reg};
                tick_now = tick_now + 32'd1;
                if ({16'd0, phase_cnt} + 32'd1 >= lap)
                begin
                    phase_cnt = '0;
                    for (i = 0; i < NCHAN; i++)
                    begin
                        if (chan_on[i])
                        begin
                            gap = tick_now - chan_due[i];
                            if (gap != '0 && !gap[NOW_W-1])
                                late = 1'b1;
                        end
                    end
                    r.any_expired = late;
                    r.heartbeat   = !late;
                end
                else
                    phase_cnt = phase_cnt + 16'd1;
            end
            OP_OPEN:
            begin
                if (tmo == '0)
                    r.status = STAT_BAD_TIMEOUT;
                else
                begin
                    r.status = STAT_NO_FREE;
                    for (i = 0; i < NCHAN; i++)
                    begin
                        if (!found && !chan_on[i])
                        begin
                            found = 1'b1;
                            chan_on[i]  = 1'b1;
                            chan_tmo[i] = tmo;
                            chan_due[i] = tick_now + {16'd0, tmo};
                            r.opened_channel = i[CHAN_W-1:0];
                            r.status = STAT_OK;
                        end
                    end
                end
            end
            OP_KICK:
            begin
                if (!chan_on[ch])
                    r.status = STAT_BAD_CHANNEL;
                else
                    chan_due[ch] = tick_now + {16'd0, chan_tmo[ch]};
            end
            default:
            begin
                if (!chan_on[ch])
                    r.status = STAT_BAD_CHANNEL;
                else
                    chan_on[ch] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [TIMEOUT_W-1:0] tmo,
                             input logic [CHAN_W-1:0] ch, input bit typed, input res_t want);
        res_t guess;
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
        @(negedge clk);
        item_bus.valid         <= 1'b1;
        item_bus.op            <= op;
        item_bus.timeout_ticks <= tmo;
        item_bus.channel       <= ch;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        guess = predict_watchdog_reply(op, tmo, ch);
        pending_replies.push_back(typed ? want : guess);
        words_sent++;
    endtask

    task automatic drain_replies();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_check_period(input logic [PERIOD_W-1:0] value);
        drain_replies();
        @(negedge clk);
        check_period_we    <= 1'b1;
        check_period_wdata <= value;
        @(negedge clk);
        check_period_we    <= 1'b0;
        period_reg = value;
    endtask

    task automatic run_random_words(input int count, input bit long_hold);
        logic [OP_W-1:0]      op;
        logic [TIMEOUT_W-1:0] tmo;
        logic [CHAN_W-1:0]    ch;
        int live [$];
        int pick;
        int n;
        int i;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_TICK;
            else if (pick < 65)
                op = OP_OPEN;
            else if (pick < 80)
                op = OP_KICK;
            else
                op = OP_CLOSE;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                tmo = '0;
            else if (pick < 10)
                tmo = '1;
            else if (pick < 25)
                tmo = TIMEOUT_W'($urandom);
            else
                tmo = TIMEOUT_W'($urandom_range(1, 40));
            live.delete();
            for (i = 0; i < NCHAN; i++)
                if (chan_on[i])
                    live.push_back(i);
            if (live.size() > 0 && $urandom_range(0, 99) < 70)
                ch = CHAN_W'(live[$urandom_range(0, live.size() - 1)]);
            else
                ch = CHAN_W'($urandom_range(0, NCHAN - 1));
            send_word(op, tmo, ch, 1'b0, '0);
            if (long_hold && n == count / 3)
                hold_req = 1'b1;
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                holds_done++;
                stall_left = HOLD_LEN - 1;
                result_bus.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 15)
            begin
                stall_left = $urandom_range(0, 7);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.status, result_bus.opened_channel,
                    result_bus.heartbeat, result_bus.any_expired};
            replies_seen++;
            heartbeats += got.heartbeat;
            expiries   += got.any_expired;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status=%0d chan=%0d hb=%0b exp=%0b",
                             got.status, got.opened_channel, got.heartbeat, got.any_expired);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.opened_channel !== want.opened_channel
                    || got.heartbeat !== want.heartbeat || got.any_expired !== want.any_expired)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at reply %0d: exp status=%0d chan=%0d hb=%0b exp=%0b, got status=%0d chan=%0d hb=%0b exp=%0b",
                                 replies_seen, want.status, want.opened_channel,
                                 want.heartbeat, want.any_expired, got.status,
                                 got.opened_channel, got.heartbeat, got.any_expired);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready)
            || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [PERIOD_W-1:0] periods [6];
        int r;
        int k;
        item_bus.valid         = 1'b0;
        item_bus.op            = OP_TICK;
        item_bus.timeout_ticks = '0;
        item_bus.channel       = '0;
        for (k = 0; k < NCHAN; k++)
        begin
            chan_on[k]  = 1'b0;
            chan_tmo[k] = '0;
            chan_due[k] = '0;
        end
        tick_now   = '0;
        phase_cnt  = '0;
        period_reg = CHECK_PERIOD_RST;

        script[0]  = '{OP_KICK,  16'd0,     4'd5,  1,  1'b1, '{STAT_BAD_CHANNEL, 4'd0, 1'b0, 1'b0}};
        script[1]  = '{OP_CLOSE, 16'd0,     4'd15, 1,  1'b1, '{STAT_BAD_CHANNEL, 4'd0, 1'b0, 1'b0}};
        script[2]  = '{OP_OPEN,  16'd0,     4'd0,  1,  1'b1, '{STAT_BAD_TIMEOUT, 4'd0, 1'b0, 1'b0}};
        script[3]  = '{OP_OPEN,  16'hFFFF,  4'd0,  1,  1'b1, '{STAT_OK,          4'd0, 1'b0, 1'b0}};
        script[4]  = '{OP_OPEN,  16'd1,     4'd0,  1,  1'b1, '{STAT_OK,          4'd1, 1'b0, 1'b0}};
        script[5]  = '{OP_TICK,  16'd0,     4'd0,  2,  1'b0, '0};
        script[6]  = '{OP_KICK,  16'd0,     4'd1,  1,  1'b0, '0};
        script[7]  = '{OP_TICK,  16'd0,     4'd0,  1,  1'b0, '0};
        script[8]  = '{OP_CLOSE, 16'd0,     4'd1,  1,  1'b1, '{STAT_OK,          4'd0, 1'b0, 1'b0}};
        script[9]  = '{OP_OPEN,  16'd2,     4'd0,  15, 1'b0, '0};
        script[10] = '{OP_OPEN,  16'd3,     4'd0,  1,  1'b1, '{STAT_NO_FREE,     4'd0, 1'b0, 1'b0}};
        script[11] = '{OP_CLOSE, 16'd0,     4'd0,  1,  1'b1, '{STAT_OK,          4'd0, 1'b0, 1'b0}};
        script[12] = '{OP_CLOSE, 16'd0,     4'd0,  1,  1'b1, '{STAT_BAD_CHANNEL, 4'd0, 1'b0, 1'b0}};

        periods = '{16'd10, 16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd1};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_check_period(16'd1);
        for (r = 0; r < 13; r++)
            for (k = 0; k < script[r].reps; k++)
                send_word(script[r].op, script[r].tmo, script[r].ch,
                          script[r].typed, script[r].want);

        for (r = 0; r < 6; r++)
        begin
            set_check_period(periods[r]);
            quiet = (r == 5);
            run_random_words(PHASE_WORDS, r == 1);
        end
        drain_replies();

        if (pending_replies.size() != 0)
            mismatches++;
        $display("sent %0d words, checked %0d replies over 7 check periods",
                 words_sent, replies_seen);
        $display("scans with heartbeat %0d, with expiry %0d, long hold-offs %0d",
                 heartbeats, expiries, holds_done);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### multi_channel_watchdog_top.f
+incdir+design
design/mcw_pkg.sv
design/mcw_item_if.sv
design/mcw_result_if.sv
design/mcw_ram.sv
design/mcw_front.sv
design/mcw_cmd_fifo.sv
design/mcw_back.sv
design/multi_channel_watchdog_top.sv
design/mcw_checker.sv
verif/tb_multi_channel_watchdog_top.sv
